[src/socd_pkg.sv]
`default_nettype none

package socd_pkg;

    typedef enum logic [1:0] {
        MODE_NEUTRAL      = 2'd0,
        MODE_LAST_PRESS   = 2'd1,
        MODE_SECOND_PRESS = 2'd2,
        MODE_PASS         = 2'd3
    } t_socd_mode;

    localparam int unsigned BTN_W = 7;
    localparam int unsigned DIR_W = 4;
    localparam int unsigned CRC_W = 8;

    localparam logic [DIR_W-1:0] DIR_UP    = 4'b0001;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 4'b0010;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0100;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b1000;

    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 8'h8C;

    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    function automatic logic [DIR_W-1:0] f_clean_pair(
        input logic [DIR_W-1:0] raw,
        input logic [DIR_W-1:0] prev,
        input t_socd_mode       mode,
        input logic [DIR_W-1:0] lo,
        input logic [DIR_W-1:0] hi
    );
        logic [DIR_W-1:0] pair;
        logic [DIR_W-1:0] res;
        logic [DIR_W-1:0] fresh;
        logic [DIR_W-1:0] held;
        pair  = lo | hi;
        res   = raw;
        fresh = (raw ^ prev) & raw & pair;
        held  = prev & pair;
        if ((raw & pair) == pair) begin
            case (mode)
                MODE_NEUTRAL: begin
                    res = raw & ~pair;
                end
                MODE_LAST_PRESS: begin
                    if ((fresh & lo) != '0) begin
                        res = raw & ~hi;
                    end else if ((fresh & hi) != '0) begin
                        res = raw & ~lo;
                    end else begin
                        res = raw & ~pair;
                    end
                end
                MODE_SECOND_PRESS: begin
                    if (held == lo) begin
                        res = raw & ~lo;
                    end else if (held == hi) begin
                        res = raw & ~hi;
                    end else begin
                        res = raw & ~pair;
                    end
                end
                default: begin
                    res = raw;
                end
            endcase
        end
        return res;
    endfunction

    // one byte of reflected CRC-8, bit at a time
    function automatic logic [CRC_W-1:0] f_crc_byte(
        input logic [CRC_W-1:0] crc_in,
        input logic [7:0]       data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[src/socd_clean.sv]
`default_nettype none

module dir_cleaner (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_adv,
    input  wire socd_pkg::t_socd_mode     i_mode,
    input  wire logic [socd_pkg::DIR_W-1:0] i_raw,
    output logic [socd_pkg::DIR_W-1:0]    o_dirs
);
    import socd_pkg::*;

    logic [DIR_W-1:0] r_prev_raw;
    logic [DIR_W-1:0] w_lr;
    logic [DIR_W-1:0] w_ud;

    always_comb begin
        w_lr   = f_clean_pair(i_raw, r_prev_raw, i_mode, DIR_LEFT, DIR_RIGHT);
        w_ud   = f_clean_pair(i_raw, r_prev_raw, i_mode, DIR_UP, DIR_DOWN);
        o_dirs = w_lr & w_ud;
    end

    // previous raw sample tracks every item, whatever the mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= '0;
        end else if (i_adv) begin
            r_prev_raw <= i_raw;
        end
    end

endmodule

`default_nettype wire

[src/socd_crc8.sv]
`default_nettype none

module socd_crc8 (
    input  wire logic [socd_pkg::BTN_W-1:0] i_buttons,
    input  wire logic [socd_pkg::DIR_W-1:0] i_dirs,
    output logic [socd_pkg::CRC_W-1:0]      o_crc
);
    import socd_pkg::*;

    logic [CRC_W-1:0] w_c1;
    logic [CRC_W-1:0] w_c2;

    // bytes: {buttons}, 0x00, {directions}
    always_comb begin
        w_c1  = f_crc_byte('0, {1'b0, i_buttons});
        w_c2  = f_crc_byte(w_c1, 8'h00);
        o_crc = f_crc_byte(w_c2, {4'b0000, i_dirs});
    end

endmodule

`default_nettype wire

[src/socd_dpad_report_builder.sv]
// Two register stages, input and output; a request waits in the input stage while the output is stalled.
// Throughput: one request per cycle while the output is not stalled; cleaning and CRC sit between the two registers.
// Upstream ready drops only while both registers hold and the output is stalled.
// Reset (i_rst_n, synchronous, active low): pipeline empty, mode neutral,
// previous sample and last-sent report cleared, first report always counts as changed.
`default_nettype none

module socd_dpad_report_builder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [6:0] button_levels, [10:7] direction_levels, [11] radio_idle, [15:12] zero
    input  wire logic [socd_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] pressed_buttons, [10:7] clean_directions, [18:11] report_crc,
    // [19] send_now, [23:20] zero
    output logic [socd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data
);
    import socd_pkg::*;

    t_socd_mode         r_mode;
    logic               r_in_valid;
    logic [BTN_W-1:0]   r_in_buttons;
    logic [DIR_W-1:0]   r_in_raw;
    logic               r_in_idle;
    logic               r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;
    logic [BTN_W-1:0]   r_last_buttons;
    logic [DIR_W-1:0]   r_last_dirs;
    logic               r_sent_before;

    logic               w_adv;
    logic [DIR_W-1:0]   w_dirs;
    logic [CRC_W-1:0]   w_crc;
    logic               w_changed;
    logic               w_send;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    dir_cleaner u_clean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_mode  (r_mode),
        .i_raw   (r_in_raw),
        .o_dirs  (w_dirs)
    );

    socd_crc8 u_crc (
        .i_buttons (r_in_buttons),
        .i_dirs    (w_dirs),
        .o_crc     (w_crc)
    );

    always_comb begin
        w_changed  = !r_sent_before || (r_in_buttons != r_last_buttons) ||
                     (w_dirs != r_last_dirs);
        w_send     = w_changed && r_in_idle;
        n_out_data = {4'b0000, w_send, w_crc, w_dirs, r_in_buttons};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_NEUTRAL;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_last_buttons <= '0;
            r_last_dirs    <= '0;
            r_sent_before  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= t_socd_mode'(i_cfg_data);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv && w_send) begin
                r_last_buttons <= r_in_buttons;
                r_last_dirs    <= w_dirs;
                r_sent_before  <= 1'b1;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_buttons <= ~s_axis_tdata[6:0];
            r_in_raw     <= ~s_axis_tdata[10:7];
            r_in_idle    <= s_axis_tdata[11];
        end
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import socd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic             send;
        logic [CRC_W-1:0] crc;
        logic [DIR_W-1:0] dir;
        logic [BTN_W-1:0] btn;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_data = '0;

    socd_dpad_report_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    t_socd_mode       cur_mode = MODE_NEUTRAL;
    logic [DIR_W-1:0] prev_raw = '0;
    logic [BTN_W-1:0] sent_btn = '0;
    logic [DIR_W-1:0] sent_dir = '0;
    logic             has_sent = 1'b0;

    t_report report_q[$];
    int      err_cnt = 0;
    int      cycle_cnt = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 20;
    int hold_len = 0;
    int hold_req_cnt = 0;
    int hold_ack_cnt = 0;
    int hold_left = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin
        if (hold_ack_cnt != hold_req_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_report exp_r;
        t_report got_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r = m_axis_tdata[19:0];
            if (report_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("tb: unexpected report %h", m_axis_tdata);
                end
            end else begin
                exp_r = report_q.pop_front();
                if (got_r.btn !== exp_r.btn || got_r.dir !== exp_r.dir ||
                    got_r.crc !== exp_r.crc || got_r.send !== exp_r.send ||
                    m_axis_tdata[23:20] !== 4'b0) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("tb: mismatch btn %h/%h dir %h/%h crc %h/%h send %b/%b pad %h",
                                 exp_r.btn, got_r.btn, exp_r.dir, got_r.dir,
                                 exp_r.crc, got_r.crc, exp_r.send, got_r.send,
                                 m_axis_tdata[23:20]);
                    end
                end
            end
        end
    end

    function automatic logic [DIR_W-1:0] resolve_pair(
        input logic [DIR_W-1:0] raw,
        input logic [DIR_W-1:0] prev,
        input logic [DIR_W-1:0] lo,
        input logic [DIR_W-1:0] hi
    );
        logic [DIR_W-1:0] both;
        logic [DIR_W-1:0] fresh;
        logic [DIR_W-1:0] held;
        both  = lo | hi;
        fresh = raw & ~prev & both;
        held  = prev & both;
        if ((raw & both) != both) return raw;
        case (cur_mode)
            MODE_NEUTRAL: begin
                return raw & ~both;
            end
            MODE_LAST_PRESS: begin
                if ((fresh & lo) != '0) return raw & ~hi;
                if ((fresh & hi) != '0) return raw & ~lo;
                return raw & ~both;
            end
            MODE_SECOND_PRESS: begin
                if (held == lo) return raw & ~lo;
                if (held == hi) return raw & ~hi;
                return raw & ~both;
            end
            default: begin
                return raw;
            end
        endcase
    endfunction

    // bitwise reflected CRC-8 over {buttons, 0x00, directions}, LSB first
    function automatic logic [CRC_W-1:0] report_crc8(
        input logic [BTN_W-1:0] btn,
        input logic [DIR_W-1:0] dir
    );
        logic [23:0]      msg;
        logic [CRC_W-1:0] c;
        logic             fb;
        msg = {4'b0, dir, 8'h00, 1'b0, btn};
        c   = '0;
        for (int i = 0; i < 24; i++) begin
            fb = c[0] ^ msg[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY_REFL;
        end
        return c;
    endfunction

    task automatic predict_report(input logic [15:0] word);
        logic [BTN_W-1:0] btn;
        logic [DIR_W-1:0] raw;
        logic [DIR_W-1:0] dir;
        logic             changed;
        t_report          r;
        btn = ~word[6:0];
        raw = ~word[10:7];
        dir = resolve_pair(raw, prev_raw, DIR_LEFT, DIR_RIGHT) &
              resolve_pair(raw, prev_raw, DIR_UP, DIR_DOWN);
        prev_raw = raw;
        changed  = !has_sent || btn != sent_btn || dir != sent_dir;
        r.btn  = btn;
        r.dir  = dir;
        r.crc  = report_crc8(btn, dir);
        r.send = changed && word[11];
        if (r.send) begin
            sent_btn = btn;
            sent_dir = dir;
            has_sent = 1'b1;
        end
        report_q.push_back(r);
    endtask

    function automatic logic [15:0] press(
        input logic [BTN_W-1:0] btn_on,
        input logic [DIR_W-1:0] dir_on,
        input logic             idle
    );
        return {4'b0, idle, ~dir_on, ~btn_on};
    endfunction

    task automatic send_item(input logic [15:0] word, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_report(word);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_socd_mode m);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_mode = m;
    endtask

    // each cycle idles with the given chance
    function automatic int sender_gap();
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        return gap;
    endfunction

    // mostly small steps from the last sample so opposing presses build up in order
    function automatic logic [15:0] next_word(input logic [15:0] prev);
        logic [15:0] w;
        int          r;
        logic [3:0]  idx;
        r = $urandom_range(0, 99);
        w = prev;
        if (r < 20) begin
            w[11] = 1'($urandom_range(0, 1));
        end else if (r < 55) begin
            idx    = 4'(7 + $urandom_range(0, 3));
            w[idx] = ~w[idx];
            w[11]  = 1'($urandom_range(0, 1));
        end else if (r < 65) begin
            idx    = 4'($urandom_range(0, 6));
            w[idx] = ~w[idx];
        end else begin
            w = 16'($urandom() & 32'h0000_0FFF);
        end
        return w;
    endfunction

    task automatic test_reset_state();
        send_item(press(7'h00, 4'h0, 1'b1), 0);
        send_item(press(7'h00, 4'h0, 1'b1), 0);
        send_item(press(7'h7F, 4'hF, 1'b0), 0);
        send_item(press(7'h7F, 4'hF, 1'b1), 1);
    endtask

    task automatic test_socd_modes();
        write_mode(MODE_LAST_PRESS);
        send_item(press(7'h00, DIR_LEFT, 1'b1), 0);
        send_item(press(7'h00, DIR_LEFT | DIR_RIGHT, 1'b1), 0);
        send_item(press(7'h00, DIR_LEFT | DIR_RIGHT, 1'b1), 0);
        send_item(press(7'h00, 4'h0, 1'b1), 0);
        send_item(press(7'h00, DIR_UP | DIR_DOWN, 1'b1), 0);
        send_item(press(7'h00, DIR_DOWN, 1'b1), 0);
        send_item(press(7'h00, DIR_UP | DIR_DOWN, 1'b1), 0);

        write_mode(MODE_SECOND_PRESS);
        send_item(press(7'h01, DIR_RIGHT, 1'b1), 0);
        send_item(press(7'h01, DIR_LEFT | DIR_RIGHT, 1'b1), 0);
        send_item(press(7'h01, 4'h0, 1'b1), 0);
        send_item(press(7'h01, 4'hF, 1'b1), 0);
        send_item(press(7'h01, 4'hF, 1'b1), 0);
        send_item(press(7'h01, DIR_UP, 1'b1), 0);
        send_item(press(7'h01, DIR_UP | DIR_DOWN, 1'b1), 0);

        write_mode(MODE_PASS);
        send_item(press(7'h7F, 4'hF, 1'b1), 0);
        send_item(press(7'h7F, 4'hF, 1'b0), 0);

        write_mode(MODE_NEUTRAL);
        send_item(press(7'h55, 4'hF, 1'b1), 0);
    endtask

    task automatic test_backpressure();
        hold_len = 80;
        hold_req_cnt++;
        for (int k = 0; k < 20; k++) begin
            send_item(16'($urandom() & 32'h0000_0FFF), 0);
        end
        wait_drain();
        for (int k = 0; k < 5; k++) begin
            send_item(16'($urandom() & 32'h0000_0FFF), 0);
        end
    endtask

    task automatic test_random_traffic();
        int          snd_pct[3] = '{34, 69, 0};
        int          rcv_pct[3] = '{69, 34, 0};
        logic [15:0] word;
        word = 16'h0FFF;
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = snd_pct[ph];
            recv_idle_pct = rcv_pct[ph];
            for (int ch = 0; ch < 3; ch++) begin
                write_mode(t_socd_mode'((ph * 3 + ch) % 4));
                for (int k = 0; k < 45; k++) begin
                    word = next_word(word);
                    send_item(word, sender_gap());
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_socd_modes();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && report_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

[socd_dpad_report_builder.f]
src/socd_pkg.sv
src/socd_clean.sv
src/socd_crc8.sv
src/socd_dpad_report_builder.sv
sim/tb.sv
